>>> design/isl_pkg.sv
// shared types, codes and defaults for the indexed sequential list
package isl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int LEN_W        = 7;
  localparam int POS_W        = 8;
  localparam int VAL_W        = 32;
  localparam int FPOS_W       = 6;

  localparam logic [LEN_W-1:0] MIN_LIMIT = 7'd10;
  localparam logic [LEN_W-1:0] CFG_RESET = 7'd64;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_SET    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]              op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [FPOS_W-1:0]       found_position;
    logic [LEN_W-1:0]        list_length;
  } out_item_t;

endpackage

>>> design/isl_ram.sv
// generic single write port ram with registered read
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/indexed_sequential_list_top.sv
// indexed sequential list: ordered word list kept in one ram with a length counter
//
//   channel  ports                          beat
//   in       in_valid in_stall in_data      one request (op, position, item_value)
//   out      out_valid out_stall out_data   one result per request
//   cfg      cfg_valid cfg_ready cfg_data   capacity_limit write
//
// one request at a time; insert and delete shift the entries behind the position, find
// scans up to length entries, and the shift and the scan move an entry a cycle through
// the one ram read port.
// synchronous active-low reset clears the length and sets the limit to 64; ram not cleared.
// a finished result waits in the output register while the next request is taken;
// out_stall holds the block only when a new result is ready and the register is full.
module indexed_sequential_list_top #(
  parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  isl_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output isl_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [isl_pkg::LEN_W-1:0] cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = isl_pkg::LEN_W;
  localparam int VW = isl_pkg::VAL_W;
  localparam logic [LW-1:0] CAP_CLAMP = LW'((CAPACITY > 127) ? 127 : CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [LW-1:0]       pos_r, pos_nxt;
  logic [VW-1:0]       val_r, val_nxt;
  logic [LW-1:0]       cnt_r, cnt_nxt;
  logic [LW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [LW-1:0]       wr_idx_r, wr_idx_nxt;
  logic [LW-1:0]       left_r, left_nxt;
  logic                pend_r, pend_nxt;
  logic                up_r, up_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [VW-1:0]       res_read_r, res_read_nxt;
  logic [isl_pkg::FPOS_W-1:0] res_fpos_r, res_fpos_nxt;
  logic [LW-1:0]       lim_cfg_r;
  isl_pkg::out_item_t  out_r;
  logic                out_valid_r;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [VW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [VW-1:0]       mem_rdata;

  logic [LW-1:0]       lim_lo, lim_eff;
  logic                in_acc, out_free, full, out_range;
  logic [isl_pkg::POS_W-1:0] cnt_ext;

  isl_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign lim_lo    = (lim_cfg_r < isl_pkg::MIN_LIMIT) ? isl_pkg::MIN_LIMIT : lim_cfg_r;
  assign lim_eff   = (lim_lo > CAP_CLAMP) ? CAP_CLAMP : lim_lo;
  assign full      = (cnt_r >= lim_eff);
  assign cnt_ext   = {1'b0, cnt_r};
  assign out_range = (in_data.position >= cnt_ext);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    left_nxt       = left_r;
    pend_nxt       = pend_r;
    up_nxt         = up_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    res_fpos_nxt   = res_fpos_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(wr_idx_r);
    mem_wdata      = mem_rdata;
    mem_raddr      = AW'(rd_idx_r);

    unique case (state_r)
      S_IDLE: begin
        mem_raddr = AW'(in_data.position);
        if (in_acc) begin
          op_nxt         = in_data.op;
          val_nxt        = in_data.item_value;
          pos_nxt        = in_data.position[LW-1:0];
          res_status_nxt = isl_pkg::ST_OK;
          res_read_nxt   = '0;
          res_fpos_nxt   = '0;
          pend_nxt       = 1'b0;
          state_nxt      = S_EMIT;
          unique case (in_data.op) inside
            isl_pkg::OP_INSERT: begin
              if (full) begin
                res_status_nxt = isl_pkg::ST_FULL;
              end else begin
                if (in_data.position > cnt_ext) begin
                  pos_nxt  = cnt_r;
                  left_nxt = '0;
                end else begin
                  left_nxt = cnt_r - in_data.position[LW-1:0];
                end
                rd_idx_nxt = cnt_r - LW'(1);
                up_nxt     = 1'b1;
                state_nxt  = (in_data.position >= cnt_ext) ? S_PUT : S_SHIFT;
              end
            end
            isl_pkg::OP_DELETE, isl_pkg::OP_GET: begin
              if (out_range) begin
                res_status_nxt = isl_pkg::ST_RANGE;
              end else begin
                state_nxt = S_READ;
              end
            end
            isl_pkg::OP_FIND: begin
              if (cnt_r == '0) begin
                res_status_nxt = isl_pkg::ST_NOTFOUND;
              end else begin
                rd_idx_nxt = '0;
                left_nxt   = cnt_r;
                state_nxt  = S_FIND;
              end
            end
            isl_pkg::OP_SET: begin
              if (out_range) begin
                res_status_nxt = isl_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_data.position);
                mem_wdata = in_data.item_value;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_read_nxt = mem_rdata;
        if (op_r == isl_pkg::OP_GET) begin
          state_nxt = S_EMIT;
        end else begin
          left_nxt   = cnt_r - LW'(1) - pos_r;
          rd_idx_nxt = pos_r + LW'(1);
          up_nxt     = 1'b0;
          if (cnt_r - LW'(1) == pos_r) begin
            cnt_nxt   = cnt_r - LW'(1);
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        mem_we = pend_r;
        if (left_r != '0) begin
          wr_idx_nxt = up_r ? rd_idx_r + LW'(1) : rd_idx_r - LW'(1);
          rd_idx_nxt = up_r ? rd_idx_r - LW'(1) : rd_idx_r + LW'(1);
          left_nxt   = left_r - LW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (up_r) begin
            state_nxt = S_PUT;
          end else begin
            cnt_nxt   = cnt_r - LW'(1);
            state_nxt = S_EMIT;
          end
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + LW'(1);
        state_nxt = S_EMIT;
      end
      S_FIND: begin
        if (pend_r && (mem_rdata == val_r)) begin
          res_fpos_nxt = wr_idx_r[isl_pkg::FPOS_W-1:0];
          pend_nxt     = 1'b0;
          state_nxt    = S_EMIT;
        end else if (left_r == '0) begin
          res_status_nxt = isl_pkg::ST_NOTFOUND;
          pend_nxt       = 1'b0;
          state_nxt      = S_EMIT;
        end else begin
          wr_idx_nxt = rd_idx_r;
          rd_idx_nxt = rd_idx_r + LW'(1);
          left_nxt   = left_r - LW'(1);
          pend_nxt   = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      lim_cfg_r   <= isl_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        lim_cfg_r <= cfg_data;
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    left_r       <= left_nxt;
    up_r         <= up_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    res_fpos_r   <= res_fpos_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_r.status         <= res_status_r;
      out_r.read_value     <= res_read_r;
      out_r.found_position <= res_fpos_r;
      out_r.list_length    <= cnt_r;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CLAMP)
    else $error("list length beyond capacity");

  a_shift_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && mem_we && left_r != '0) |-> (mem_waddr != mem_raddr))
    else $error("shift writes the entry it reads");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == isl_pkg::ST_FULL) |->
      (out_r.list_length >= isl_pkg::MIN_LIMIT))
    else $error("full reported below minimum limit");

endmodule
